// ===== design/tcb_pkg.sv =====
// Shared constants, types and helpers of the text console buffer.
package tcb_pkg;

    localparam int MAX_COLS = 80;
    localparam int MAX_ROWS = 25;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(CELLS);

    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int CELL_W   = 2 * BYTE_W;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(MAX_COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(MAX_ROWS - 1);
    localparam logic [COL_W-1:0] COLS_RESET = COL_W'(80);
    localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(25);

    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
    localparam logic [BYTE_W-1:0] ATTR_DEFAULT = 8'h0F;

    typedef enum logic [2:0] {
        REQ_PRINT      = 3'd0,
        REQ_PUT        = 3'd1,
        REQ_SET_CURSOR = 3'd2,
        REQ_CLEAR      = 3'd3,
        REQ_SCROLL     = 3'd4,
        REQ_FILL       = 3'd5,
        REQ_READ       = 3'd6,
        REQ_NONE       = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        SW_RESET,
        SW_CLEAR,
        SW_FILL,
        SW_COPY,
        SW_BLANK
    } t_sw_mode;

    typedef struct packed {
        logic [COL_W-1:0]  cols;
        logic [ROW_W-1:0]  rows;
        logic [BYTE_W-1:0] blank;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic     load;
        logic     exec;
        logic     sw_start;
        t_sw_mode sw_mode;
        logic     sw_step;
        logic     out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic need_scroll;
        logic fill_ok;
        logic multi_row;
        logic sw_last;
    } t_sts;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] y,
                                                    input logic [COL_W-1:0] x);
        return ADDR_W'(y) * ADDR_W'(MAX_COLS) + ADDR_W'(x);
    endfunction

endpackage

// ===== design/tcb_if.sv =====
// Request and response channel interfaces of the text console buffer.
interface tcb_in_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 req_type;
    logic [tcb_pkg::BYTE_W-1:0] pos_x;
    logic [tcb_pkg::BYTE_W-1:0] pos_y;
    logic [tcb_pkg::BYTE_W-1:0] char_code;
    logic [tcb_pkg::BYTE_W-1:0] attr;

    modport source (output valid, req_type, pos_x, pos_y, char_code, attr, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, char_code, attr, output ready);
endinterface

interface tcb_out_if;
    logic                       valid;
    logic                       ready;
    logic [tcb_pkg::COL_W-1:0]  cursor_x;
    logic [tcb_pkg::ROW_W-1:0]  cursor_y;
    logic [tcb_pkg::BYTE_W-1:0] cell_char;
    logic [tcb_pkg::BYTE_W-1:0] cell_attr;

    modport source (output valid, cursor_x, cursor_y, cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_x, cursor_y, cell_char, cell_attr, output ready);
endinterface

// ===== design/tcb_regs.sv =====
// APB configuration registers of the text console buffer.
module tcb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcb_pkg::PADDR_W-1:0] paddr,
    input  logic [tcb_pkg::PDATA_W-1:0] pwdata,
    output logic [tcb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output tcb_pkg::t_cfg               o_cfg
);
    import tcb_pkg::*;

    typedef enum logic [1:0] {
        REG_COLS  = 2'd0,
        REG_ROWS  = 2'd1,
        REG_BLANK = 2'd2
    } t_reg_idx;

    logic [COL_W-1:0]  r_cols;
    logic [ROW_W-1:0]  r_rows;
    logic [BYTE_W-1:0] r_blank;
    logic              wr;
    t_reg_idx          idx;

    assign wr     = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= COLS_RESET;
            r_rows  <= ROWS_RESET;
            r_blank <= ATTR_DEFAULT;
        end else if (wr) begin
            case (idx)
                REG_COLS:  r_cols  <= pwdata[COL_W-1:0];
                REG_ROWS:  r_rows  <= pwdata[ROW_W-1:0];
                REG_BLANK: r_blank <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_COLS:  prdata = PDATA_W'(r_cols);
            REG_ROWS:  prdata = PDATA_W'(r_rows);
            REG_BLANK: prdata = PDATA_W'(r_blank);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = '{cols: r_cols, rows: r_rows, blank: r_blank};

endmodule

// ===== design/tcb_dp.sv =====
// Datapath: cell memory, cursor, sweep counters and result register.
module tcb_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tcb_pkg::t_cfg              i_cfg,
    input  tcb_pkg::t_cmd              i_cmd,
    input  logic [2:0]                 i_req_type,
    input  logic [tcb_pkg::BYTE_W-1:0] i_pos_x,
    input  logic [tcb_pkg::BYTE_W-1:0] i_pos_y,
    input  logic [tcb_pkg::BYTE_W-1:0] i_char_code,
    input  logic [tcb_pkg::BYTE_W-1:0] i_attr,
    output tcb_pkg::t_sts              o_sts,
    output logic [tcb_pkg::COL_W-1:0]  o_cursor_x,
    output logic [tcb_pkg::ROW_W-1:0]  o_cursor_y,
    output logic [tcb_pkg::BYTE_W-1:0] o_cell_char,
    output logic [tcb_pkg::BYTE_W-1:0] o_cell_attr
);
    import tcb_pkg::*;

    logic [CELL_W-1:0] r_mem [CELLS];

    // latched item
    t_req              r_req;
    logic [BYTE_W-1:0] r_px, r_py, r_ch, r_at;

    logic [COL_W-1:0]  r_cur_x, n_cur_x;
    logic [ROW_W-1:0]  r_cur_y, n_cur_y;

    logic [COL_W-1:0]  r_sx;
    logic [ROW_W-1:0]  r_sy;
    t_sw_mode          r_mode;

    logic              r_cp_vld;
    logic [ADDR_W-1:0] r_cp_addr;
    logic [CELL_W-1:0] r_rd_data;
    logic              r_rd_ok;

    logic [COL_W-1:0]  r_o_cx;
    logic [ROW_W-1:0]  r_o_cy;
    logic [CELL_W-1:0] r_o_cell;

    logic [COL_W-1:0]  w;
    logic [ROW_W-1:0]  h;
    logic              pos_ok, print_wr, need_scroll, sw_last;
    logic [BYTE_W-1:0] col1, col2;
    logic [ROW_W:0]    row1, row2;
    logic [COL_W-1:0]  set_x, x_end;
    logic [ROW_W-1:0]  set_y, y_end, y_start;
    logic [CELL_W-1:0] sw_data, wr_data;
    logic [ADDR_W-1:0] wr_addr, rd_addr, sw_addr;
    logic              wr_en, rd_en;

    // used size, clamped to 1..MAX
    always_comb begin
        if (i_cfg.cols == '0)                        w = COL_W'(1);
        else if (i_cfg.cols > COL_W'(MAX_COLS))      w = COL_W'(MAX_COLS);
        else                                         w = i_cfg.cols;
        if (i_cfg.rows == '0)                        h = ROW_W'(1);
        else if (i_cfg.rows > ROW_W'(MAX_ROWS))      h = ROW_W'(MAX_ROWS);
        else                                         h = i_cfg.rows;
    end

    assign pos_ok = (BYTE_W'(w) > r_px) && (BYTE_W'(h) > r_py);

    // print: cursor step, wrap, scroll check
    always_comb begin
        print_wr = (r_cur_x < w) && (r_cur_y < h);
        if (r_ch == CH_NEWLINE) begin
            col1 = '0;
            row1 = (ROW_W+1)'(r_cur_y) + 1'b1;
        end else if (r_ch == CH_RETURN) begin
            col1 = '0;
            row1 = (ROW_W+1)'(r_cur_y);
        end else begin
            col1 = BYTE_W'(r_cur_x) + 1'b1;
            row1 = (ROW_W+1)'(r_cur_y);
        end
        if (col1 >= BYTE_W'(w)) begin
            col2 = '0;
            row2 = row1 + 1'b1;
        end else begin
            col2 = col1;
            row2 = row1;
        end
        need_scroll = row2 >= (ROW_W+1)'(h);
    end

    assign set_x = (r_px >= BYTE_W'(w)) ? w - 1'b1 : r_px[COL_W-1:0];
    assign set_y = (r_py >= BYTE_W'(h)) ? h - 1'b1 : r_py[ROW_W-1:0];

    // sweep bounds and fill data
    always_comb begin
        case (r_mode)
            SW_RESET: begin
                x_end = LAST_COL;  y_end = LAST_ROW;  sw_data = '0;
            end
            SW_CLEAR: begin
                x_end = w - 1'b1;  y_end = h - 1'b1;  sw_data = {r_at, CH_SPACE};
            end
            SW_FILL: begin
                x_end = w - 1'b1;  y_end = r_sy;      sw_data = {r_at, r_ch};
            end
            SW_COPY: begin
                x_end = w - 1'b1;  y_end = h - 1'b1;  sw_data = '0;
            end
            SW_BLANK: begin
                x_end = w - 1'b1;  y_end = r_sy;      sw_data = {i_cfg.blank, CH_SPACE};
            end
            default: begin
                x_end = LAST_COL;  y_end = LAST_ROW;  sw_data = '0;
            end
        endcase
        case (i_cmd.sw_mode)
            SW_FILL:  y_start = r_py[ROW_W-1:0];
            SW_COPY:  y_start = ROW_W'(1);
            SW_BLANK: y_start = h - 1'b1;
            default:  y_start = '0;
        endcase
    end

    assign sw_last = (r_sx == x_end) && (r_sy == y_end);
    assign sw_addr = cell_addr(r_sy, r_sx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx   <= '0;
            r_sy   <= '0;
            r_mode <= SW_RESET;
        end else if (i_cmd.sw_start) begin
            r_mode <= i_cmd.sw_mode;
            r_sx   <= '0;
            r_sy   <= y_start;
        end else if (i_cmd.sw_step) begin
            if (r_sx == x_end) begin
                r_sx <= '0;
                r_sy <= r_sy + 1'b1;
            end else begin
                r_sx <= r_sx + 1'b1;
            end
        end
    end

    // cursor
    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (i_cmd.exec) begin
            case (r_req)
                REQ_PRINT: begin
                    n_cur_x = col2[COL_W-1:0];
                    n_cur_y = row2[ROW_W-1:0];
                end
                REQ_SET_CURSOR: begin
                    n_cur_x = set_x;
                    n_cur_y = set_y;
                end
                default: ;
            endcase
        end
        if (i_cmd.sw_step && sw_last) begin
            case (r_mode)
                SW_CLEAR: begin
                    n_cur_x = '0;
                    n_cur_y = '0;
                end
                SW_BLANK: begin
                    n_cur_x = '0;
                    n_cur_y = h - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_cp_vld <= 1'b0;
        end else begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_cp_vld <= i_cmd.sw_step && (r_mode == SW_COPY);
        end
    end

    // memory port select; a copy write comes in the cycle after its read
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sw_addr;
        wr_data = sw_data;
        if (r_cp_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_cp_addr;
            wr_data = r_rd_data;
        end else if (i_cmd.sw_step && (r_mode != SW_COPY)) begin
            wr_en   = 1'b1;
        end else if (i_cmd.exec && (r_req == REQ_PRINT) && print_wr &&
                     (r_ch != CH_NEWLINE) && (r_ch != CH_RETURN)) begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(r_cur_y, r_cur_x);
            wr_data = {r_at, r_ch};
        end else if (i_cmd.exec && (r_req == REQ_PUT) && pos_ok) begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(r_py[ROW_W-1:0], r_px[COL_W-1:0]);
            wr_data = {r_at, r_ch};
        end

        rd_en   = 1'b0;
        rd_addr = sw_addr;
        if (i_cmd.sw_step && (r_mode == SW_COPY)) begin
            rd_en   = 1'b1;
        end else if (i_cmd.exec && (r_req == REQ_READ) && pos_ok) begin
            rd_en   = 1'b1;
            rd_addr = cell_addr(r_py[ROW_W-1:0], r_px[COL_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= sw_addr - ADDR_W'(MAX_COLS);
        if (i_cmd.exec && (r_req == REQ_READ)) r_rd_ok <= pos_ok;
        if (i_cmd.load) begin
            r_req <= t_req'(i_req_type);
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_ch  <= i_char_code;
            r_at  <= i_attr;
        end
        if (i_cmd.out_load) begin
            r_o_cx   <= n_cur_x;
            r_o_cy   <= n_cur_y;
            r_o_cell <= ((r_req == REQ_READ) && r_rd_ok) ? r_rd_data : '0;
        end
    end

    assign o_sts = '{req:         r_req,
                     need_scroll: need_scroll,
                     fill_ok:     BYTE_W'(h) > r_py,
                     multi_row:   h > ROW_W'(1),
                     sw_last:     sw_last};

    assign o_cursor_x  = r_o_cx;
    assign o_cursor_y  = r_o_cy;
    assign o_cell_char = r_o_cell[BYTE_W-1:0];
    assign o_cell_attr = r_o_cell[CELL_W-1:BYTE_W];

endmodule

// ===== design/tcb_ctrl.sv =====
// Controller: sequences requests, sweeps and the result handshake.
module tcb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  tcb_pkg::t_sts i_sts,
    output tcb_pkg::t_cmd o_cmd
);
    import tcb_pkg::*;

    typedef enum logic [3:0] {
        S_RST_START,
        S_RST_SWEEP,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_COPY,
        S_DRAIN,
        S_SWEEP,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free, fin;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.sw_mode = SW_RESET;
        fin         = 1'b0;
        case (r_state)
            S_RST_START: begin
                o_cmd.sw_start = 1'b1;
                n_state        = S_RST_SWEEP;
            end
            S_RST_SWEEP: begin
                o_cmd.sw_step = 1'b1;
                if (i_sts.sw_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_sts.req)
                    REQ_PRINT, REQ_SCROLL: begin
                        if ((i_sts.req == REQ_PRINT) && !i_sts.need_scroll) begin
                            fin = 1'b1;
                        end else if (i_sts.multi_row) begin
                            o_cmd.sw_start = 1'b1;
                            o_cmd.sw_mode  = SW_COPY;
                            n_state        = S_COPY;
                        end else begin
                            o_cmd.sw_start = 1'b1;
                            o_cmd.sw_mode  = SW_BLANK;
                            n_state        = S_SWEEP;
                        end
                    end
                    REQ_CLEAR: begin
                        o_cmd.sw_start = 1'b1;
                        o_cmd.sw_mode  = SW_CLEAR;
                        n_state        = S_SWEEP;
                    end
                    REQ_FILL: begin
                        if (i_sts.fill_ok) begin
                            o_cmd.sw_start = 1'b1;
                            o_cmd.sw_mode  = SW_FILL;
                            n_state        = S_SWEEP;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    REQ_READ: n_state = S_READ;
                    default:  fin = 1'b1;
                endcase
            end
            S_READ: fin = 1'b1;
            S_COPY: begin
                o_cmd.sw_step = 1'b1;
                if (i_sts.sw_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                o_cmd.sw_start = 1'b1;
                o_cmd.sw_mode  = SW_BLANK;
                n_state        = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.sw_step = 1'b1;
                if (i_sts.sw_last) fin = 1'b1;
            end
            S_FIN: fin = 1'b1;
            default: n_state = S_IDLE;
        endcase
        if (fin) begin
            if (out_free) begin
                o_cmd.out_load = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end else begin
                n_state        = S_FIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RST_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/text_console_buffer.sv =====
// Top level of the text console buffer: channels, registers, controller, datapath.
//
// A text-mode console of MAX_COLS x MAX_ROWS cells (80 x 25), each a character byte and
// an attribute byte, held in one single-port-write, single-port-read memory, plus a
// cursor. Each request item yields exactly one response item carrying the cursor after
// the request and, for a read, the cell contents. After reset the block sweeps the whole
// memory to zero, one cell a cycle, and takes no item until that sweep is done; APB
// writes are taken throughout. Items are handled one at a time. Clear writes all w*h
// used cells and fill line the w cells of one row, with w and h the used columns and
// rows, since each cell costs one memory write. A scroll, by request or by printing
// past the last row, copies (h-1)*w cells at one per cycle through the read-then-write
// pipeline, then blanks the bottom row. The response sits in an output register, so
// the next item is taken while the last response waits. Config registers:
// columns_in_use at 0x0, rows_in_use at 0x4, blank_attr at 0x8; write them
// only while the block is idle.
module text_console_buffer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcb_in_if.sink                      i_req,
    tcb_out_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcb_pkg::PADDR_W-1:0] paddr,
    input  logic [tcb_pkg::PDATA_W-1:0] pwdata,
    output logic [tcb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import tcb_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    tcb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tcb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_req_type  (i_req.req_type),
        .i_pos_x     (i_req.pos_x),
        .i_pos_y     (i_req.pos_y),
        .i_char_code (i_req.char_code),
        .i_attr      (i_req.attr),
        .o_sts       (sts),
        .o_cursor_x  (o_rsp.cursor_x),
        .o_cursor_y  (o_rsp.cursor_y),
        .o_cell_char (o_rsp.cell_char),
        .o_cell_attr (o_rsp.cell_attr)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    // one item in flight: no second accept right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("item accepted while another is in progress");

    // cursor reported in a response always lies inside the grid
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((o_rsp.cursor_x < COL_W'(MAX_COLS)) &&
                         (o_rsp.cursor_y < ROW_W'(MAX_ROWS))))
        else $error("response cursor outside the grid");

    // the clearing sweep holds off input after reset
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!i_req.ready && !o_rsp.valid))
        else $error("input taken before memory clear");

    // no response without a result load for a request in flight feeding it
    a_rsp_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(cmd.out_load))
        else $error("response raised without a result load");

endmodule
